### hw/rtl/bbsm_pkg.sv
// Shared constants, codes and types of the bad block spare mapper.
package bbsm_pkg;

    localparam int MAX_BAD = 32;
    localparam int CNT_W   = $clog2(MAX_BAD + 1);
    localparam int IDX_W   = $clog2(MAX_BAD);
    localparam int BLK_W   = 32;
    localparam int BPC_W   = 24;
    localparam int LIM_W   = BPC_W + 1;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [BPC_W-1:0] BPC_RESET = BPC_W'(1024);

    // request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_BUILD  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_MANY = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic KIND_PAIR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_APPEND_FULL,
        OP_BUILD,
        OP_BUILD_EMPTY
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [CNT_W-1:0] idx;   // list slot for append, list length for build
        logic [BLK_W-1:0] blk;
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } t_bk_state;

    typedef enum logic [2:0] {
        STEP_INFO,
        STEP_T1,
        STEP_T2,
        STEP_SPARE,
        STEP_NF
    } t_step;

    typedef struct packed {
        logic             kind;
        logic [BLK_W-1:0] bad;
        logic [BLK_W-1:0] spare;
        logic [BLK_W-1:0] info;
        logic [BLK_W-1:0] t1;
        logic [BLK_W-1:0] t2;
        logic [BLK_W-1:0] nf;
        logic [BLK_W-1:0] left;
        logic [1:0]       status;
        logic             last;
    } t_result;

endpackage

### hw/rtl/bbsm_cmd_queue.sv
// Short command queue between the front and back parts.
module bbsm_cmd_queue import bbsm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd];
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

### hw/rtl/bbsm_front.sv
// Front part: accepts requests, tracks list length, classifies into commands.
module bbsm_front import bbsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [1:0]       i_req_type,
    input  logic [BLK_W-1:0] i_block_number,
    input  logic             i_q_full,
    output logic             o_busy,
    output logic             o_push,
    output t_cmd             o_cmd
);

    // list length as seen in issue order; the back applies the same order
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;

    assign accept = i_start && !i_q_full;
    assign o_busy = i_q_full;

    always_comb begin
        n_count    = r_count;
        o_push     = 1'b0;
        o_cmd.op   = OP_APPEND;
        o_cmd.idx  = r_count;
        o_cmd.blk  = i_block_number;
        if (accept) begin
            case (i_req_type)
                REQ_APPEND: begin
                    o_push = 1'b1;
                    if (r_count >= CNT_W'(MAX_BAD)) begin
                        o_cmd.op = OP_APPEND_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_BUILD: begin
                    o_push   = 1'b1;
                    o_cmd.op = (r_count == '0) ? OP_BUILD_EMPTY : OP_BUILD;
                end
                REQ_CLEAR: begin
                    n_count = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/bbsm_back.sv
// Back part: holds the bad list, runs the spare search and drives results.
module bbsm_back import bbsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    input  logic [BPC_W-1:0] i_bpc,
    output logic             o_valid,
    output t_result          o_res
);

    logic [BLK_W-1:0] r_mem [MAX_BAD];
    logic [BLK_W-1:0] r_rdata;
    logic [BLK_W-1:0] r_bad;

    t_bk_state        r_state, n_state;
    t_step            r_step, n_step;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_dv, n_dv;
    logic             r_dlast, n_dlast;
    logic [BLK_W-1:0] r_cand, n_cand;
    logic [BLK_W-1:0] r_info, n_info;
    logic [BLK_W-1:0] r_t1, n_t1;
    logic [BLK_W-1:0] r_t2, n_t2;
    logic             r_valid, n_valid;
    t_result          r_res, n_res;

    logic             mem_we;
    logic [BLK_W-1:0] lim_ext;
    logic             hit;
    logic             done;

    assign lim_ext = BLK_W'({i_bpc, 1'b0});
    assign hit     = r_dv && (r_rdata == r_cand);
    assign done    = r_dv && r_dlast && !hit;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_n     = r_n;
        n_k     = r_k;
        n_ptr   = r_ptr;
        n_dv    = 1'b0;
        n_dlast = r_dlast;
        n_cand  = r_cand;
        n_info  = r_info;
        n_t1    = r_t1;
        n_t2    = r_t2;
        n_valid = 1'b0;
        n_res   = r_res;
        o_pop   = 1'b0;
        mem_we  = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    case (i_cmd.op)
                        OP_APPEND: begin
                            mem_we = 1'b1;
                        end
                        OP_APPEND_FULL: begin
                            n_valid      = 1'b1;
                            n_res        = '0;
                            n_res.kind   = KIND_SUMMARY;
                            n_res.status = ST_FULL;
                            n_res.last   = 1'b1;
                        end
                        OP_BUILD_EMPTY: begin
                            n_valid      = 1'b1;
                            n_res        = '0;
                            n_res.kind   = KIND_SUMMARY;
                            n_res.status = ST_EMPTY;
                            n_res.last   = 1'b1;
                        end
                        OP_BUILD: begin
                            n_n     = i_cmd.idx;
                            n_k     = '0;
                            n_cand  = '0;
                            n_ptr   = '0;
                            n_step  = STEP_INFO;
                            n_state = BK_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            BK_SCAN: begin
                if (hit) begin
                    // candidate is listed: try the next block, rescan
                    n_cand = r_cand + 1'b1;
                    n_ptr  = '0;
                end else if (done) begin
                    n_cand = r_cand + 1'b1;
                    n_ptr  = '0;
                    case (r_step)
                        STEP_INFO: begin
                            n_info = r_cand;
                            n_step = STEP_T1;
                        end
                        STEP_T1: begin
                            n_t1   = r_cand;
                            n_step = STEP_T2;
                        end
                        STEP_T2: begin
                            n_t2   = r_cand;
                            n_step = STEP_SPARE;
                        end
                        STEP_SPARE: begin
                            n_valid = 1'b1;
                            n_res   = '0;
                            if (r_cand > lim_ext) begin
                                n_res.kind   = KIND_SUMMARY;
                                n_res.info   = r_info;
                                n_res.t1     = r_t1;
                                n_res.t2     = r_t2;
                                n_res.status = ST_TOO_MANY;
                                n_res.last   = 1'b1;
                                n_state      = BK_IDLE;
                            end else begin
                                n_res.kind  = KIND_PAIR;
                                n_res.bad   = r_bad;
                                n_res.spare = r_cand;
                                n_k         = r_k + 1'b1;
                                if (r_k + 1'b1 == r_n) begin
                                    n_step = STEP_NF;
                                end
                            end
                        end
                        STEP_NF: begin
                            n_valid      = 1'b1;
                            n_res        = '0;
                            n_res.kind   = KIND_SUMMARY;
                            n_res.info   = r_info;
                            n_res.t1     = r_t1;
                            n_res.t2     = r_t2;
                            n_res.nf     = r_cand;
                            n_res.left   = (lim_ext > r_cand) ? lim_ext - r_cand : '0;
                            n_res.status = ST_OK;
                            n_res.last   = 1'b1;
                            n_state      = BK_IDLE;
                        end
                        default: n_state = BK_IDLE;
                    endcase
                end else if (r_ptr < r_n) begin
                    // issue the next list read
                    n_dv    = 1'b1;
                    n_dlast = (r_ptr == r_n - 1'b1);
                    n_ptr   = r_ptr + 1'b1;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_step  <= STEP_INFO;
            r_n     <= '0;
            r_k     <= '0;
            r_ptr   <= '0;
            r_dv    <= 1'b0;
            r_dlast <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_n     <= n_n;
            r_k     <= n_k;
            r_ptr   <= n_ptr;
            r_dv    <= n_dv;
            r_dlast <= n_dlast;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_info <= n_info;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_res  <= n_res;
    end

    // bad list: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_cmd.idx[IDX_W-1:0]] <= i_cmd.blk;
        end
        r_rdata <= r_mem[r_ptr[IDX_W-1:0]];
        r_bad   <= r_mem[r_k[IDX_W-1:0]];
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hw/rtl/bad_block_spare_mapper.sv
// Top level of the bad block spare mapper: APB register, front, queue and back.
// Flow: with the back idle, an append-full or empty-build summary passes the command
//   queue and then the registered result to the result ports; an append only writes the list.
//   A build tests each candidate against the list, at most n+4 candidates
//   (n = list length) plus one per listed block skipped, and gives at most one result
//   per candidate.
// Throughput: start is taken each cycle while the 4-entry command queue has room.
// Reset (synchronous, i_rst_n low): list empty, queue empty, blocks_per_cylinder 1024;
//   list contents are not cleared. Results are never stalled by the receiver.
module bad_block_spare_mapper import bbsm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // request transaction
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_req_type,
    input  logic [BLK_W-1:0] i_block_number,
    // result transaction
    output logic             o_valid,
    output logic             o_record_kind,
    output logic [BLK_W-1:0] o_bad_block,
    output logic [BLK_W-1:0] o_spare_block,
    output logic [BLK_W-1:0] o_info_block,
    output logic [BLK_W-1:0] o_table_first,
    output logic [BLK_W-1:0] o_table_second,
    output logic [BLK_W-1:0] o_next_free,
    output logic [BLK_W-1:0] o_blocks_left,
    output logic [1:0]       o_status,
    output logic             o_last
);

    // register index sits in paddr[2]; only blocks_per_cylinder exists
    localparam logic CFG_IDX_BPC = 1'b0;

    logic [BPC_W-1:0] r_bpc;
    logic             cfg_wr;

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_cmd    front_cmd;
    t_cmd    head_cmd;
    t_result res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_BPC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc <= BPC_RESET;
        end else if (cfg_wr) begin
            r_bpc <= pwdata[BPC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_BPC) ? {(32 - BPC_W)'(0), r_bpc} : '0;

    // front: classifies each request against the issue-order list length
    bbsm_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_req_type     (i_req_type),
        .i_block_number (i_block_number),
        .i_q_full       (q_full),
        .o_busy         (busy),
        .o_push         (q_push),
        .o_cmd          (front_cmd)
    );

    bbsm_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back: list memory, spare search and registered result
    bbsm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (head_cmd),
        .o_pop     (q_pop),
        .i_bpc     (r_bpc),
        .o_valid   (o_valid),
        .o_res     (res)
    );

    assign o_record_kind  = res.kind;
    assign o_bad_block    = res.bad;
    assign o_spare_block  = res.spare;
    assign o_info_block   = res.info;
    assign o_table_first  = res.t1;
    assign o_table_second = res.t2;
    assign o_next_free    = res.nf;
    assign o_blocks_left  = res.left;
    assign o_status       = res.status;
    assign o_last         = res.last;

endmodule
